@@ design/packed_pixel_alpha_blend_macros.svh @@
// assertion macros for the packed pixel alpha blender
// no dependencies; included by the top level only
`ifndef PACKED_PIXEL_ALPHA_BLEND_MACROS_SVH
`define PACKED_PIXEL_ALPHA_BLEND_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled during reset
`define PPAB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define PPAB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define PPAB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PPAB_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/ppab_pkg.sv @@
// shared constants for the packed pixel alpha blender
// no dependencies; imported by every module of the block
`default_nettype none

package ppab_pkg;

    // field widths
    localparam int WORD_W    = 32;
    localparam int COORD_W   = 12;
    localparam int STRIDE_W  = 16;
    localparam int BPP_W     = 3;
    localparam int CFG_IDX_W = 2;

    // pixel format codes (bytes per pixel)
    localparam logic [BPP_W-1:0] FMT_RGB332   = 3'd1;
    localparam logic [BPP_W-1:0] FMT_RGB565   = 3'd2;
    localparam logic [BPP_W-1:0] FMT_RGB888   = 3'd3;
    localparam logic [BPP_W-1:0] FMT_XRGB8888 = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd2;

    // register reset values
    localparam logic [BPP_W-1:0]    BPP_RESET    = FMT_RGB565;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = '0;
    localparam logic [WORD_W-1:0]   BASE_RESET   = '0;

    // channel spread masks
    localparam logic [WORD_W-1:0] MASK_332 = 32'h0000_38E3;
    localparam logic [WORD_W-1:0] MASK_565 = 32'h07E0_F81F;
    localparam logic [WORD_W-1:0] MASK_RB  = 32'h00FF_00FF;
    localparam logic [WORD_W-1:0] MASK_G   = 32'h0000_FF00;
    localparam logic [WORD_W-1:0] MASK_8   = 32'h0000_00FF;

endpackage

`default_nettype wire

@@ design/packed_pixel_alpha_blend.sv @@
// An accepted beat is held in the input register; its address and blend results
// are registered in the result register, which drives the outputs. Throughput:
// one beat per cycle while the output is not stalled; the input register and the
// result register form a two-stage pipeline, and o_stall rises only when both
// hold beats and the output is stalled. Reset (synchronous, i_rst_n low) empties
// both stages and sets bytes_per_pixel to 2 (RGB565), stride and base to zero.
// Depends on ppab_pkg, ppab_addr, ppab_blend, packed_pixel_alpha_blend_macros.svh.
`default_nettype none

`include "packed_pixel_alpha_blend_macros.svh"

module packed_pixel_alpha_blend
    import ppab_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data,
    // input beats
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [COORD_W-1:0]   i_pixel_x,
    input  wire logic [COORD_W-1:0]   i_pixel_y,
    input  wire logic [WORD_W-1:0]    i_source_color,
    input  wire logic [WORD_W-1:0]    i_dest_pixel,
    // result beats
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic      [WORD_W-1:0]    o_byte_address,
    output logic      [WORD_W-1:0]    o_blended_pixel
);

    logic [BPP_W-1:0]    r_bytes_per_pixel;
    logic [STRIDE_W-1:0] r_row_stride;
    logic [WORD_W-1:0]   r_frame_base;

    logic                r_s1_valid;
    logic [COORD_W-1:0]  r_pixel_x;
    logic [COORD_W-1:0]  r_pixel_y;
    logic [WORD_W-1:0]   r_source_color;
    logic [WORD_W-1:0]   r_dest_pixel;

    logic                r_s2_valid;
    logic [WORD_W-1:0]   r_byte_address;
    logic [WORD_W-1:0]   r_blended_pixel;

    logic [WORD_W-1:0]   n_byte_address;
    logic [WORD_W-1:0]   n_blended_pixel;
    logic                s2_load;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_per_pixel <= BPP_RESET;
            r_row_stride      <= STRIDE_RESET;
            r_frame_base      <= BASE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BPP:    r_bytes_per_pixel <= i_cfg_data[BPP_W-1:0];
                CFG_STRIDE: r_row_stride      <= i_cfg_data[STRIDE_W-1:0];
                CFG_BASE:   r_frame_base      <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // pipeline flow control
    assign s2_load = !r_s2_valid || !i_stall;
    assign o_stall = r_s1_valid && !s2_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_s1_valid <= i_valid;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_pixel_x      <= i_pixel_x;
            r_pixel_y      <= i_pixel_y;
            r_source_color <= i_source_color;
            r_dest_pixel   <= i_dest_pixel;
        end
    end

    // address and blend logic between the two registers
    ppab_addr u_addr (
        .i_frame_base      (r_frame_base),
        .i_row_stride      (r_row_stride),
        .i_bytes_per_pixel (r_bytes_per_pixel),
        .i_pixel_x         (r_pixel_x),
        .i_pixel_y         (r_pixel_y),
        .o_byte_address    (n_byte_address)
    );

    ppab_blend u_blend (
        .i_bytes_per_pixel (r_bytes_per_pixel),
        .i_source_color    (r_source_color),
        .i_dest_pixel      (r_dest_pixel),
        .o_blended_pixel   (n_blended_pixel)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (s2_load && r_s1_valid) begin
            r_byte_address  <= n_byte_address;
            r_blended_pixel <= n_blended_pixel;
        end
    end

    assign o_valid         = r_s2_valid;
    assign o_byte_address  = r_byte_address;
    assign o_blended_pixel = r_blended_pixel;

    // input stalls only with both stages full and the output held
    `PPAB_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, o_stall, r_s1_valid && r_s2_valid && i_stall)
    // an accepted beat lands in the input register
    `PPAB_ASSERT_NXT(a_accept_fills_s1, i_clk, i_rst_n, i_valid && !o_stall, r_s1_valid)
    // no format drives the top byte of the pixel
    `PPAB_ASSERT_IMP(a_top_byte_zero, i_clk, i_rst_n, o_valid, o_blended_pixel[31:24] == 8'h00)

endmodule

`default_nettype wire

@@ design/ppab_addr.sv @@
// frame byte address: base + y*stride + x*bytes_per_pixel, modulo 2^32
// depends on ppab_pkg
`default_nettype none

module ppab_addr
    import ppab_pkg::*;
(
    input  wire logic [WORD_W-1:0]   i_frame_base,
    input  wire logic [STRIDE_W-1:0] i_row_stride,
    input  wire logic [BPP_W-1:0]    i_bytes_per_pixel,
    input  wire logic [COORD_W-1:0]  i_pixel_x,
    input  wire logic [COORD_W-1:0]  i_pixel_y,
    output logic      [WORD_W-1:0]   o_byte_address
);

    logic [COORD_W+STRIDE_W-1:0] row_offset;
    logic [COORD_W+BPP_W-1:0]    col_offset;

    // row and column products
    assign row_offset = {{STRIDE_W{1'b0}}, i_pixel_y} * {{COORD_W{1'b0}}, i_row_stride};
    assign col_offset = {{BPP_W{1'b0}}, i_pixel_x} * {{COORD_W{1'b0}}, i_bytes_per_pixel};

    // wrapping sum
    assign o_byte_address = i_frame_base
                          + {{(WORD_W-COORD_W-STRIDE_W){1'b0}}, row_offset}
                          + {{(WORD_W-COORD_W-BPP_W){1'b0}}, col_offset};

endmodule

`default_nettype wire

@@ design/ppab_blend.sv @@
// per-format alpha blend of one source color over one destination pixel
// depends on ppab_pkg
`default_nettype none

module ppab_blend
    import ppab_pkg::*;
(
    input  wire logic [BPP_W-1:0]  i_bytes_per_pixel,
    input  wire logic [WORD_W-1:0] i_source_color,
    input  wire logic [WORD_W-1:0] i_dest_pixel,
    output logic      [WORD_W-1:0] o_blended_pixel
);

    // back + ((alpha * (fore - back)) mod 2^32 >> sh), modulo 2^32
    function automatic logic [WORD_W-1:0] mix(
        input logic [WORD_W-1:0] back,
        input logic [WORD_W-1:0] fore,
        input logic [7:0]        alpha,
        input logic [3:0]        sh
    );
        logic [WORD_W-1:0] diff;
        logic [WORD_W-1:0] prod;
        diff = fore - back;
        prod = diff * {24'b0, alpha};
        return back + (prod >> sh);
    endfunction

    logic [WORD_W-1:0] fore_332, back_332, res_332;
    logic [WORD_W-1:0] fore_565, back_565, res_565;
    logic [WORD_W-1:0] res_888;
    logic [WORD_W-1:0] res_rb, res_g;
    logic [7:0]        alpha_8;
    logic [WORD_W-1:0] lane_mix;

    assign alpha_8 = i_source_color[31:24];

    // rgb332: spread into 0x38E3 and blend with 3 alpha bits
    always_comb begin
        fore_332 = ({24'b0, i_source_color[7:0]} | ({24'b0, i_source_color[7:0]} << 9))
                 & MASK_332;
        back_332 = ({24'b0, i_dest_pixel[7:0]} | ({24'b0, i_dest_pixel[7:0]} << 9))
                 & MASK_332;
        res_332  = mix(back_332, fore_332, {5'b0, i_source_color[31:29]}, 4'd3) & MASK_332;
    end

    // rgb565: spread into 0x07E0F81F and blend with 5 alpha bits
    always_comb begin
        fore_565 = ({16'b0, i_source_color[15:0]} | ({16'b0, i_source_color[15:0]} << 16))
                 & MASK_565;
        back_565 = ({16'b0, i_dest_pixel[15:0]} | ({16'b0, i_dest_pixel[15:0]} << 16))
                 & MASK_565;
        res_565  = mix(back_565, fore_565, {3'b0, i_source_color[31:27]}, 4'd5) & MASK_565;
    end

    // rgb888: three independent byte lanes
    always_comb begin
        res_888  = '0;
        lane_mix = '0;
        for (int k = 0; k < 3; k++) begin
            lane_mix = mix({24'b0, i_dest_pixel[8*k +: 8]},
                           {24'b0, i_source_color[8*k +: 8]}, alpha_8, 4'd8) & MASK_8;
            res_888[8*k +: 8] = lane_mix[7:0];
        end
    end

    // xrgb8888: red/blue pair and green apart
    assign res_rb = mix(i_dest_pixel & MASK_RB, i_source_color & MASK_RB, alpha_8, 4'd8)
                  & MASK_RB;
    assign res_g  = mix(i_dest_pixel & MASK_G, i_source_color & MASK_G, alpha_8, 4'd8)
                  & MASK_G;

    // format select, fold spread channels back together
    always_comb begin
        unique case (i_bytes_per_pixel)
            FMT_RGB332:   o_blended_pixel = {24'b0, res_332[7:0] | res_332[16:9]};
            FMT_RGB565:   o_blended_pixel = {16'b0, res_565[15:0] | res_565[31:16]};
            FMT_RGB888:   o_blended_pixel = res_888;
            FMT_XRGB8888: o_blended_pixel = res_rb | res_g;
            default:      o_blended_pixel = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking bench for packed_pixel_alpha_blend: directed table, then random phases
// depends on ppab_pkg and the block's rtl; the bench keeps its own blend and address predictor
`timescale 1ns / 1ps

module tb_top;
    import ppab_pkg::*;

    // bench constants
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 12;
    localparam int PRESSURE_PHASE = 5;
    localparam int BEATS_KNOWN    = 220;
    localparam int BEATS_UNKNOWN  = 60;

    // format codes that select no blend, and the register index past the last one
    localparam logic [BPP_W-1:0]     FMT_UNUSED_0 = 3'd0;
    localparam logic [BPP_W-1:0]     FMT_UNUSED_5 = 3'd5;
    localparam logic [BPP_W-1:0]     FMT_UNUSED_6 = 3'd6;
    localparam logic [BPP_W-1:0]     FMT_UNUSED_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] byte_address;
        logic [WORD_W-1:0] blended_pixel;
    } t_blend_result;

    typedef struct packed {
        logic [BPP_W-1:0]    fmt;
        logic [STRIDE_W-1:0] stride;
        logic [WORD_W-1:0]   base;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [WORD_W-1:0]   src;
        logic [WORD_W-1:0]   dst;
        logic                typed;
        t_blend_result       known;
    } t_directed_row;

    // directed rows: format extremes, address wrap, alpha zero and full, unknown formats
    localparam int DIRECTED_ROWS = 20;
    localparam t_directed_row DIRECTED [DIRECTED_ROWS] = '{
        '{FMT_RGB565, 16'd0, 32'h0, 12'd0, 12'd0, 32'h0000_0000, 32'h0000_0000,
          1'b1, '{32'h0000_0000, 32'h0000_0000}},
        '{FMT_RGB565, 16'd0, 32'h0, 12'd4095, 12'd4095, 32'h07FF_FFFF, 32'hFFFF_1234,
          1'b1, '{32'h0000_1FFE, 32'h0000_1234}},
        '{FMT_RGB565, 16'd0, 32'h0, 12'd1, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, '{32'h0000_0002, 32'h0000_FFFF}},
        '{FMT_RGB565, 16'd0, 32'h0, 12'd2048, 12'd0, 32'hF800_FFFF, 32'h0000_0000,
          1'b0, '0},
        '{FMT_RGB565, 16'd0, 32'h0, 12'd5, 12'd7, 32'hFFFF_0000, 32'h0000_FFFF,
          1'b0, '0},
        '{FMT_RGB332, 16'hFFFF, 32'hFFFF_FFFF, 12'd0, 12'd0, 32'h1FFF_FFFF, 32'hFFFF_FF5A,
          1'b1, '{32'hFFFF_FFFF, 32'h0000_005A}},
        '{FMT_RGB332, 16'hFFFF, 32'hFFFF_FFFF, 12'd1, 12'd0, 32'h0000_0000, 32'h0000_0000,
          1'b1, '{32'h0000_0000, 32'h0000_0000}},
        '{FMT_RGB332, 16'hFFFF, 32'hFFFF_FFFF, 12'd4095, 12'd4095, 32'h0000_00FF,
          32'h0000_00A5, 1'b1, '{32'h0FFE_FFFF, 32'h0000_00A5}},
        '{FMT_RGB332, 16'hFFFF, 32'hFFFF_FFFF, 12'd7, 12'd3, 32'hE000_00FF, 32'h0000_0000,
          1'b0, '0},
        '{FMT_RGB332, 16'hFFFF, 32'hFFFF_FFFF, 12'd9, 12'd1, 32'hFFFF_FF00, 32'hFFFF_FFFF,
          1'b0, '0},
        '{FMT_RGB888, 16'd100, 32'h0000_1000, 12'd2, 12'd3, 32'h00AB_CDEF, 32'hFF12_3456,
          1'b1, '{32'h0000_1132, 32'h0012_3456}},
        '{FMT_RGB888, 16'd100, 32'h0000_1000, 12'd4095, 12'd4095, 32'hFFFF_FFFF,
          32'h0000_0000, 1'b0, '0},
        '{FMT_RGB888, 16'd100, 32'h0000_1000, 12'd0, 12'd0, 32'h8000_0000, 32'h00FF_FFFF,
          1'b0, '0},
        '{FMT_XRGB8888, 16'd16384, 32'h8000_0000, 12'd10, 12'd1, 32'h00FF_FFFF,
          32'hFF12_3456, 1'b1, '{32'h8000_4028, 32'h0012_3456}},
        '{FMT_XRGB8888, 16'd16384, 32'h8000_0000, 12'd4095, 12'd4095, 32'hFFFF_FFFF,
          32'h0000_0000, 1'b0, '0},
        '{FMT_XRGB8888, 16'd16384, 32'h8000_0000, 12'd3, 12'd2, 32'h7F00_0000,
          32'hFFFF_FFFF, 1'b0, '0},
        '{FMT_UNUSED_0, 16'd7, 32'h0000_0005, 12'd9, 12'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, '{32'h0000_0013, 32'h0000_0000}},
        '{FMT_UNUSED_7, 16'd1, 32'h0000_0000, 12'd4095, 12'd4095, 32'hFFFF_FFFF,
          32'h1234_5678, 1'b1, '{32'h0000_7FF8, 32'h0000_0000}},
        '{FMT_UNUSED_5, 16'hFFFF, 32'h0000_0000, 12'd4095, 12'd4095, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 1'b1, '{32'h0FFF_3FFC, 32'h0000_0000}},
        '{FMT_UNUSED_6, 16'd0, 32'hFFFF_FFF0, 12'd3, 12'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, '{32'h0000_0002, 32'h0000_0000}}
    };

    // format used by each random phase
    localparam logic [BPP_W-1:0] PHASE_FMT [PHASES] = '{
        FMT_RGB332, FMT_RGB565, FMT_RGB888, FMT_XRGB8888, FMT_UNUSED_0, FMT_RGB565,
        FMT_XRGB8888, FMT_RGB332, FMT_UNUSED_5, FMT_RGB888, FMT_UNUSED_6, FMT_UNUSED_7
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [COORD_W-1:0]   i_pixel_x;
    logic [COORD_W-1:0]   i_pixel_y;
    logic [WORD_W-1:0]    i_source_color;
    logic [WORD_W-1:0]    i_dest_pixel;
    logic                 o_valid;
    logic                 i_stall;
    logic [WORD_W-1:0]    o_byte_address;
    logic [WORD_W-1:0]    o_blended_pixel;

    // bench copy of the registers
    logic [BPP_W-1:0]    fmt_q;
    logic [STRIDE_W-1:0] stride_q;
    logic [WORD_W-1:0]   base_q;

    t_blend_result pending_blends[$];
    int            mismatch_count = 0;
    int            hold_request   = 0;
    bit            src_gaps_on    = 1'b1;
    bit            sink_stalls_on = 1'b1;

    packed_pixel_alpha_blend u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_source_color  (i_source_color),
        .i_dest_pixel    (i_dest_pixel),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_byte_address  (o_byte_address),
        .o_blended_pixel (o_blended_pixel)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // back + (alpha * (fore - back)) >> shift, everything wrapping at 32 bits
    function automatic logic [WORD_W-1:0] lerp_toward(logic [WORD_W-1:0] back,
                                                      logic [WORD_W-1:0] fore,
                                                      logic [WORD_W-1:0] alpha,
                                                      int unsigned shift);
        logic [WORD_W-1:0] diff;
        logic [WORD_W-1:0] prod;
        diff = fore - back;
        prod = alpha * diff;
        return back + (prod >> shift);
    endfunction

    // frame address and blended pixel under the current register copy
    function automatic t_blend_result predict_blend(logic [COORD_W-1:0] x,
                                                    logic [COORD_W-1:0] y,
                                                    logic [WORD_W-1:0] src,
                                                    logic [WORD_W-1:0] dst);
        t_blend_result     res;
        logic [WORD_W-1:0] fore;
        logic [WORD_W-1:0] back;
        logic [WORD_W-1:0] mixed;
        logic [WORD_W-1:0] green;
        logic [WORD_W-1:0] alpha;
        res.byte_address = base_q + WORD_W'(y) * WORD_W'(stride_q)
                         + WORD_W'(x) * WORD_W'(fmt_q);
        res.blended_pixel = '0;
        case (fmt_q)
            FMT_RGB332: begin
                fore  = ({24'h0, src[7:0]} | ({24'h0, src[7:0]} << 9)) & MASK_332;
                back  = ({24'h0, dst[7:0]} | ({24'h0, dst[7:0]} << 9)) & MASK_332;
                mixed = lerp_toward(back, fore, {29'h0, src[31:29]}, 3) & MASK_332;
                res.blended_pixel = (mixed | (mixed >> 9)) & MASK_8;
            end
            FMT_RGB565: begin
                fore  = ({16'h0, src[15:0]} | {src[15:0], 16'h0}) & MASK_565;
                back  = ({16'h0, dst[15:0]} | {dst[15:0], 16'h0}) & MASK_565;
                mixed = lerp_toward(back, fore, {27'h0, src[31:27]}, 5) & MASK_565;
                res.blended_pixel = (mixed | (mixed >> 16)) & 32'h0000_FFFF;
            end
            FMT_RGB888: begin
                alpha = {24'h0, src[31:24]};
                for (int k = 0; k < 3; k++) begin
                    fore  = (src >> (8 * k)) & MASK_8;
                    back  = (dst >> (8 * k)) & MASK_8;
                    mixed = lerp_toward(back, fore, alpha, 8) & MASK_8;
                    res.blended_pixel |= mixed << (8 * k);
                end
            end
            FMT_XRGB8888: begin
                alpha = {24'h0, src[31:24]};
                mixed = lerp_toward(dst & MASK_RB, src & MASK_RB, alpha, 8) & MASK_RB;
                green = lerp_toward(dst & MASK_G, src & MASK_G, alpha, 8) & MASK_G;
                res.blended_pixel = mixed | green;
            end
            default: res.blended_pixel = '0;
        endcase
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // one register write; valid stays up for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        if (!i_cfg_valid) i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BPP:    fmt_q    = data[BPP_W-1:0];
            CFG_STRIDE: stride_q = data[STRIDE_W-1:0];
            CFG_BASE:   base_q   = data;
            default:    ;
        endcase
    endtask

    // drain the pipeline, then rewrite every register plus the spare index
    task automatic reconfigure(input logic [BPP_W-1:0] fmt, input logic [STRIDE_W-1:0] stride,
                               input logic [WORD_W-1:0] base, input bit junk_bits);
        logic [WORD_W-1:0] data;
        i_valid <= 1'b0;
        while (pending_blends.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        data = junk_bits ? $urandom() : '0;
        data[BPP_W-1:0] = fmt;
        write_reg(CFG_BPP, data);
        data = junk_bits ? $urandom() : '0;
        data[STRIDE_W-1:0] = stride;
        write_reg(CFG_STRIDE, data);
        write_reg(CFG_BASE, base);
        write_reg(CFG_SPARE, $urandom());
        i_cfg_valid <= 1'b0;
    endtask

    // offer one pixel beat, after a random gap when gaps are on, record what it should produce
    task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [WORD_W-1:0] src, input logic [WORD_W-1:0] dst,
                              input bit typed, input t_blend_result known);
        int unsigned gap;
        gap = src_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_pixel_x      <= x;
        i_pixel_y      <= y;
        i_source_color <= src;
        i_dest_pixel   <= dst;
        do @(posedge i_clk); while (o_stall);
        pending_blends.push_back(typed ? known : predict_blend(x, y, src, dst));
    endtask

    // stimulus
    initial begin : stimulus
        logic [BPP_W-1:0]    fmt;
        logic [STRIDE_W-1:0] stride;
        logic [WORD_W-1:0]   base;
        logic [WORD_W-1:0]   src;
        int                  beats;
        t_directed_row       row;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_BPP;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_pixel_x      = '0;
        i_pixel_y      = '0;
        i_source_color = '0;
        i_dest_pixel   = '0;
        fmt_q          = BPP_RESET;
        stride_q       = STRIDE_RESET;
        base_q         = BASE_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, registers rewritten whenever a row asks for others
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.fmt != fmt_q || row.stride != stride_q || row.base != base_q)
                reconfigure(row.fmt, row.stride, row.base, 1'b0);
            send_pixel(row.x, row.y, row.src, row.dst, row.typed, row.known);
        end

        // random phases over every format, stride and base extremes
        for (int phase = 0; phase < PHASES; phase++) begin
            fmt = PHASE_FMT[phase];
            case (phase % 3)
                0:       stride = '0;
                1:       stride = '1;
                default: stride = STRIDE_W'($urandom());
            endcase
            case ((phase + 1) % 3)
                0:       base = '0;
                1:       base = '1;
                default: base = $urandom();
            endcase
            reconfigure(fmt, stride, base, 1'b1);
            src_gaps_on = (phase % 4 != 1);
            sink_stalls_on <= (phase % 4 != 2);
            if (phase == PRESSURE_PHASE) hold_request <= hold_request + 1;
            beats = (fmt >= FMT_RGB332 && fmt <= FMT_XRGB8888) ? BEATS_KNOWN : BEATS_UNKNOWN;
            repeat (beats) begin
                src = $urandom();
                case ($urandom_range(0, 7))
                    0:       src[31:24] = 8'h00;
                    1:       src[31:24] = 8'hFF;
                    default: ;
                endcase
                send_pixel(random_coord(), random_coord(), src, $urandom(), 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        // wait for the last results, then let the pipeline settle
        while (pending_blends.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result side: short random stalls per beat, one long hold on request
    initial begin : result_sink
        int unsigned stall_left;
        int          holds_served;
        stall_left   = 0;
        holds_served = 0;
        i_stall      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != holds_served) begin
                holds_served = hold_request;
                i_stall <= 1'b1;
                for (int held = 0; held < LONG_HOLD; held++) @(posedge i_clk);
                i_stall <= 1'b0;
                stall_left = 0;
            end else if (o_valid && !i_stall) begin
                stall_left = sink_stalls_on ? $urandom_range(0, 3) : 0;
                i_stall <= (stall_left != 0);
            end else if (stall_left != 0) begin
                stall_left--;
                i_stall <= (stall_left != 0);
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_blend_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_blends.size() == 0) begin
                $error("result beat with nothing expected: byte_address %h blended_pixel %h",
                       o_byte_address, o_blended_pixel);
                mismatch_count++;
            end else begin
                want = pending_blends.pop_front();
                if (o_byte_address !== want.byte_address) begin
                    $error("byte_address mismatch: expected %h, got %h",
                           want.byte_address, o_byte_address);
                    mismatch_count++;
                end
                if (o_blended_pixel !== want.blended_pixel) begin
                    $error("blended_pixel mismatch: expected %h, got %h",
                           want.blended_pixel, o_blended_pixel);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on any channel
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

@@ files.f @@
+incdir+design
design/ppab_pkg.sv
design/ppab_addr.sv
design/ppab_blend.sv
design/packed_pixel_alpha_blend.sv
sim/tb_top.sv
